// File: rtl/dtu_pkg.sv
// types, constants and lookup functions shared by the date conversion block
`timescale 1ns / 1ps

package dtu_pkg;

    localparam logic [11:0] YEAR_MIN       = 12'd2000;
    localparam logic [11:0] YEAR_MAX       = 12'd2099;
    localparam logic [31:0] BASE_SECS      = 32'd946684800;  // 10957 days at 2000-01-01
    localparam logic [31:0] SECS_PER_YEAR  = 32'd31536000;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN   = 32'd60;
    localparam logic [3:0]  MONTH_JAN      = 4'd1;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;
    localparam logic [5:0]  HOURS_PER_DAY  = 6'd24;
    localparam logic [5:0]  MINS_PER_HOUR  = 6'd60;
    // base day count plus epoch weekday offset, reduced mod 7, less one for the day field
    localparam logic [7:0]  WEEKDAY_BIAS   = 8'd5;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [5:0]  day_of_month;
        logic [5:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_dt_in;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] unix_seconds;
        logic [7:0]  bcd_seconds;
        logic [7:0]  bcd_minutes;
        logic [7:0]  bcd_hours;
        logic [2:0]  weekday;
        logic [7:0]  bcd_day;
        logic [7:0]  bcd_month;
        logic [7:0]  bcd_year;
    } t_dt_out;

    typedef struct packed {
        logic ok;
        logic leap;
    } t_chk;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // seconds in the months before month m of a common year
    function automatic logic [24:0] month_base_secs(input logic [3:0] m);
        logic [24:0] s;
        case (m)
            4'd1:    s = 25'd0;
            4'd2:    s = 25'd2678400;
            4'd3:    s = 25'd5097600;
            4'd4:    s = 25'd7776000;
            4'd5:    s = 25'd10368000;
            4'd6:    s = 25'd13046400;
            4'd7:    s = 25'd15638400;
            4'd8:    s = 25'd18316800;
            4'd9:    s = 25'd20995200;
            4'd10:   s = 25'd23587200;
            4'd11:   s = 25'd26265600;
            4'd12:   s = 25'd28857600;
            default: s = 25'd0;
        endcase
        return s;
    endfunction

    // days before month m, mod 7
    function automatic logic [2:0] month_base_mod7(input logic [3:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // two bcd digits for values below 100; multiply by 103/1024 gives the exact tens digit
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] p;
        logic [3:0]  q;
        logic [6:0]  qx;
        logic [6:0]  r;
        p  = {7'd0, v} * 14'd103;
        q  = p[13:10];
        qx = {3'd0, q};
        r  = v - ((qx << 3) + (qx << 1));
        return {q, r[3:0]};
    endfunction

endpackage

// File: rtl/dtu_in_if.sv
// handshake channel carrying one calendar date and time
`timescale 1ns / 1ps

interface dtu_in_if;
    logic            valid;
    logic            ready;
    dtu_pkg::t_dt_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dtu_out_if.sv
// handshake channel carrying one conversion result
`timescale 1ns / 1ps

interface dtu_out_if;
    logic             valid;
    logic             ready;
    dtu_pkg::t_dt_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dtu_check.sv
// range checks on the date and time fields, with leap year flag
`timescale 1ns / 1ps

module dtu_check (
    input  dtu_pkg::t_dt_in i_dt,
    output dtu_pkg::t_chk   o_chk
);
    import dtu_pkg::*;

    logic       year_ok;
    logic       month_ok;
    logic       day_ok;
    logic       time_ok;
    logic       leap;
    logic [4:0] mlen;

    assign leap     = (i_dt.year[1:0] == 2'd0);
    assign year_ok  = (i_dt.year >= YEAR_MIN) && (i_dt.year <= YEAR_MAX);
    assign month_ok = (i_dt.month >= MONTH_JAN) && (i_dt.month <= MONTH_DEC);
    // february gains a day in a leap year
    assign mlen     = month_len(i_dt.month) + {4'd0, (i_dt.month == MONTH_FEB) && leap};
    assign day_ok   = (i_dt.day_of_month != 6'd0) && (i_dt.day_of_month <= {1'b0, mlen});
    assign time_ok  = (i_dt.hour < HOURS_PER_DAY) && (i_dt.minute < MINS_PER_HOUR)
                   && (i_dt.second < MINS_PER_HOUR);

    assign o_chk.ok   = year_ok && month_ok && day_ok && time_ok;
    assign o_chk.leap = leap;

endmodule

// File: rtl/dtu_conv.sv
// unix seconds, weekday and bcd bytes for a checked date and time
`timescale 1ns / 1ps

module dtu_conv (
    input  dtu_pkg::t_dt_in  i_dt,
    input  dtu_pkg::t_chk    i_chk,
    output dtu_pkg::t_dt_out o_res
);
    import dtu_pkg::*;

    logic [11:0] yo_full;
    logic [6:0]  yo;
    logic [7:0]  yo3;
    logic [5:0]  leap_days;
    logic        adj;
    logic [5:0]  extra_days;
    logic [31:0] unix;
    logic [7:0]  wsum;
    logic [13:0] wprod;
    logic [7:0]  wq;
    logic [7:0]  wrem;
    logic [7:0]  wmod;
    logic [2:0]  wday;

    assign yo_full   = i_dt.year - YEAR_MIN;
    assign yo        = yo_full[6:0];
    // leap days in the years before this one
    assign yo3       = {1'b0, yo} + 8'd3;
    assign leap_days = yo3[7:2];
    assign adj       = (i_dt.month > MONTH_FEB) && i_chk.leap;
    assign extra_days = leap_days + {5'd0, adj} + i_dt.day_of_month - 6'd1;

    // constant products side by side, summed once
    assign unix = BASE_SECS
                + {25'd0, yo} * SECS_PER_YEAR
                + {7'd0, month_base_secs(i_dt.month)}
                + {26'd0, extra_days} * SECS_PER_DAY
                + {26'd0, i_dt.hour} * SECS_PER_HOUR
                + {26'd0, i_dt.minute} * SECS_PER_MIN
                + {26'd0, i_dt.second};

    // a common year is one weekday on, so the day count mod 7 folds to a narrow sum
    assign wsum  = WEEKDAY_BIAS + {1'b0, yo} + {2'd0, leap_days}
                 + {5'd0, month_base_mod7(i_dt.month)} + {7'd0, adj}
                 + {2'd0, i_dt.day_of_month};
    // quotient by 36/256 is floor or one short, fixed by a single subtract
    assign wprod = {6'd0, wsum} * 14'd36;
    assign wq    = {2'd0, wprod[13:8]};
    assign wrem  = wsum - ((wq << 3) - wq);
    assign wmod  = (wrem >= 8'd7) ? (wrem - 8'd7) : wrem;
    assign wday  = wmod[2:0] + 3'd1;

    always_comb begin
        o_res = '0;
        if (i_chk.ok) begin
            o_res.valid_res    = 1'b1;
            o_res.unix_seconds = unix;
            o_res.bcd_seconds  = to_bcd({1'b0, i_dt.second});
            o_res.bcd_minutes  = to_bcd({1'b0, i_dt.minute});
            o_res.bcd_hours    = to_bcd({1'b0, i_dt.hour});
            o_res.weekday      = wday;
            o_res.bcd_day      = to_bcd({1'b0, i_dt.day_of_month});
            o_res.bcd_month    = to_bcd({3'd0, i_dt.month});
            o_res.bcd_year     = to_bcd(yo);
        end
    end

endmodule

// File: rtl/datetime_to_unix_and_bcd.sv
// top level: input register, checks and conversion, result register
// a result passes the input register and then the result register (two register stages) before it is shown
// throughput: one item per cycle while results are taken, set by the single conversion stage between the two registers
// the input register still takes one item while a finished result waits to be taken
// reset (synchronous, active low) clears both valid flags; payload registers keep their contents
`timescale 1ns / 1ps

module datetime_to_unix_and_bcd (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtu_in_if.sink     i_in,
    dtu_out_if.source  o_out
);
    import dtu_pkg::*;

    logic    r_s1_vld;
    t_dt_in  r_s1_dt;
    logic    r_o_vld;
    t_dt_out r_o_res;
    t_dt_out n_o_res;
    t_chk    chk;
    logic    out_adv;
    logic    in_rdy;

    assign out_adv = !r_o_vld || o_out.ready;
    assign in_rdy  = !r_s1_vld || out_adv;

    dtu_check u_check (
        .i_dt  (r_s1_dt),
        .o_chk (chk)
    );

    dtu_conv u_conv (
        .i_dt  (r_s1_dt),
        .i_chk (chk),
        .o_res (n_o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_s1_vld <= i_in.valid;
            end
            if (out_adv) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_rdy) begin
            r_s1_dt <= i_in.data;
        end
        if (out_adv && r_s1_vld) begin
            r_o_res <= n_o_res;
        end
    end

    assign i_in.ready  = in_rdy;
    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_o_res;

endmodule

// File: rtl/dtu_checker.sv
// port-level assertions for the date conversion block, bound to the top level
`timescale 1ns / 1ps

module dtu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input dtu_pkg::t_dt_out i_out_data
);
    import dtu_pkg::*;

    // nothing shown in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // input backpressure only when the result register is full and stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a stalled result");

    // an invalid date gives an all-zero result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.valid_res |-> i_out_data == '0)
        else $error("invalid result carries non-zero fields");

    // a valid date has a weekday and decimal digits
    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.valid_res |->
            i_out_data.weekday != 3'd0 && i_out_data.bcd_seconds[3:0] <= 4'd9
            && i_out_data.bcd_year[3:0] <= 4'd9 && i_out_data.bcd_year[7:4] <= 4'd9)
        else $error("valid result with bad weekday or bcd digit");

endmodule

bind datetime_to_unix_and_bcd dtu_checker u_dtu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
